### design/running_mean_variance_top_macros.svh
// ----------------------------------------------------------------------------
// Running mean and variance: assertion macros
// Shared assertion forms used by the running mean and variance block.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_VARIANCE_TOP_MACROS_SVH
`define RUNNING_MEAN_VARIANCE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RMV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rmv_pkg.sv
// ----------------------------------------------------------------------------
// Running mean and variance: package
// Control word format and the microprogram of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rmv_pkg;

  typedef logic [3:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQX,
    OP_SET_MEAN,
    OP_DIV,
    OP_FIN_MEAN,
    OP_SET_M2,
    OP_FIN_M2,
    OP_SQM,
    OP_VAR,
    OP_EMIT,
    OP_RESTART
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_IDX_ZERO,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e hold;
    cond_e branch;
    step_t target;
  } ctrl_t;

  localparam step_t ST_FETCH   = 4'd0;
  localparam step_t ST_SQX     = 4'd1;
  localparam step_t ST_SET_M   = 4'd2;
  localparam step_t ST_DIV_M   = 4'd3;
  localparam step_t ST_FIN_M   = 4'd4;
  localparam step_t ST_SET_S   = 4'd5;
  localparam step_t ST_DIV_S   = 4'd6;
  localparam step_t ST_FIN_S   = 4'd7;
  localparam step_t ST_SQM     = 4'd8;
  localparam step_t ST_VAR     = 4'd9;
  localparam step_t ST_EMIT    = 4'd10;
  localparam step_t ST_RESTART = 4'd11;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    begin
      w = '{op: OP_NOP, hold: C_NEVER, branch: C_ALWAYS, target: ST_FETCH};
      case (s)
        ST_FETCH:   w = '{op: OP_LOAD,     hold: C_NO_IN,    branch: C_NEVER,
                          target: ST_FETCH};
        ST_SQX:     w = '{op: OP_SQX,      hold: C_NEVER,    branch: C_IDX_ZERO,
                          target: ST_RESTART};
        ST_SET_M:   w = '{op: OP_SET_MEAN, hold: C_NEVER,    branch: C_NEVER,
                          target: ST_FETCH};
        ST_DIV_M:   w = '{op: OP_DIV,      hold: C_DIV_MORE, branch: C_NEVER,
                          target: ST_FETCH};
        ST_FIN_M:   w = '{op: OP_FIN_MEAN, hold: C_NEVER,    branch: C_NEVER,
                          target: ST_FETCH};
        ST_SET_S:   w = '{op: OP_SET_M2,   hold: C_NEVER,    branch: C_NEVER,
                          target: ST_FETCH};
        ST_DIV_S:   w = '{op: OP_DIV,      hold: C_DIV_MORE, branch: C_NEVER,
                          target: ST_FETCH};
        ST_FIN_S:   w = '{op: OP_FIN_M2,   hold: C_NEVER,    branch: C_NEVER,
                          target: ST_FETCH};
        ST_SQM:     w = '{op: OP_SQM,      hold: C_NEVER,    branch: C_NEVER,
                          target: ST_FETCH};
        ST_VAR:     w = '{op: OP_VAR,      hold: C_NEVER,    branch: C_NEVER,
                          target: ST_FETCH};
        ST_EMIT:    w = '{op: OP_EMIT,     hold: C_OUT_BUSY, branch: C_ALWAYS,
                          target: ST_FETCH};
        ST_RESTART: w = '{op: OP_RESTART,  hold: C_NEVER,    branch: C_ALWAYS,
                          target: ST_EMIT};
        default:    w = '{op: OP_NOP,      hold: C_NEVER,    branch: C_ALWAYS,
                          target: ST_FETCH};
      endcase
      return w;
    end
  endfunction

endpackage

`default_nettype wire

### design/running_mean_variance_top.sv
// ----------------------------------------------------------------------------
// Running mean and variance
// Microcoded sequencer over a shared multiplier and a bit-serial divider that
// updates the running mean and second moment of a sample stream.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  sample_index_i, sample_value_i
// out      output     out_valid_o/out_stall_i mean_out_o, variance_out_o
//
// An update runs the one-bit-per-cycle divider in two passes, one for the
// mean and one for the second moment. An index of zero skips the divider and
// restarts the mean and second moment from the sample. A new transfer is taken
// only at the fetch step, while a finished result may still wait in the output
// register. Reset clears the mean, the second moment, the step counter and the
// output valid flag. A stalled output holds the sequencer at its emit step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "running_mean_variance_top_macros.svh"

module running_mean_variance_top #(
  parameter int SAMPLE_BITS = 14,
  parameter int INDEX_BITS  = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [INDEX_BITS-1:0]                sample_index_i,
  input  wire logic [SAMPLE_BITS-1:0]               sample_value_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0]          mean_out_o,
  output logic [2*SAMPLE_BITS+FRAC_BITS-1:0]        variance_out_o
);
  import rmv_pkg::*;

  localparam int MEAN_BITS = SAMPLE_BITS + FRAC_BITS;
  localparam int MOM_BITS  = 2 * SAMPLE_BITS + FRAC_BITS;
  localparam int PROD_BITS = 2 * MEAN_BITS;
  localparam int REM_BITS  = INDEX_BITS + 1;
  localparam int CNT_BITS  = $clog2(MOM_BITS + 1);

  step_t                  step_q, step_d;
  ctrl_t                  cw;
  logic [INDEX_BITS-1:0]  n_q;
  logic [SAMPLE_BITS-1:0] x_q;
  logic [MOM_BITS-1:0]    xsq_q;
  logic [MEAN_BITS-1:0]   mean_q;
  logic [MOM_BITS-1:0]    m2_q;
  logic [PROD_BITS-1:0]   prod_q;
  logic [MOM_BITS-1:0]    var_q;
  logic                   up_q;
  logic [MOM_BITS-1:0]    dq_q;
  logic [REM_BITS-1:0]    rem_q;
  logic [CNT_BITS-1:0]    cnt_q;
  logic                   out_valid_q;
  logic                   out_valid_d;
  logic [MEAN_BITS-1:0]   mean_o_q;
  logic [MOM_BITS-1:0]    var_o_q;

  logic                   in_acc;
  logic                   out_busy;
  logic                   hold_c;
  logic                   branch_c;
  logic [MEAN_BITS-1:0]   xs;
  logic [MEAN_BITS-1:0]   mul_a;
  logic [PROD_BITS-1:0]   mul_p;
  logic [REM_BITS-1:0]    div_d;
  logic [REM_BITS:0]      r2;
  logic [REM_BITS:0]      r2_sub;
  logic                   q_bit;
  logic                   rnd;
  logic [MOM_BITS-1:0]    msq;

  function automatic logic cond_true(cond_e c, logic no_in, logic idx_zero,
                                     logic div_more, logic busy);
    logic r;
    begin
      case (c)
        C_NEVER:    r = 1'b0;
        C_ALWAYS:   r = 1'b1;
        C_NO_IN:    r = no_in;
        C_IDX_ZERO: r = idx_zero;
        C_DIV_MORE: r = div_more;
        C_OUT_BUSY: r = busy;
        default:    r = 1'b0;
      endcase
      return r;
    end
  endfunction

  assign cw         = ucode(step_q);
  assign in_stall_o = (step_q != ST_FETCH);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_busy   = out_valid_q && out_stall_i;

  assign hold_c   = cond_true(cw.hold, !in_valid_i, (n_q == '0),
                              (cnt_q != CNT_BITS'(1)), out_busy);
  assign branch_c = cond_true(cw.branch, !in_valid_i, (n_q == '0),
                              (cnt_q != CNT_BITS'(1)), out_busy);

  always_comb begin
    if (hold_c) begin
      step_d = step_q;
    end else if (branch_c) begin
      step_d = cw.target;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  assign out_valid_d = out_busy || (cw.op == OP_EMIT);

  assign xs     = {x_q, {FRAC_BITS{1'b0}}};
  assign mul_a  = (cw.op == OP_SQX) ? MEAN_BITS'(x_q) : mean_q;
  assign mul_p  = mul_a * mul_a;
  assign div_d  = REM_BITS'(n_q) + REM_BITS'(1);
  assign r2     = {rem_q, dq_q[MOM_BITS-1]};
  assign r2_sub = r2 - {1'b0, div_d};
  assign q_bit  = (r2 >= {1'b0, div_d});
  assign rnd    = (rem_q != '0);
  assign msq    = prod_q[PROD_BITS-1:FRAC_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_FETCH;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      mean_q      <= '0;
      m2_q        <= '0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      case (cw.op)
        OP_SET_MEAN: cnt_q <= CNT_BITS'(MEAN_BITS);
        OP_SET_M2:   cnt_q <= CNT_BITS'(MOM_BITS);
        OP_DIV:      cnt_q <= cnt_q - CNT_BITS'(1);
        OP_FIN_MEAN: begin
          if (up_q) begin
            mean_q <= mean_q + dq_q[MEAN_BITS-1:0];
          end else begin
            mean_q <= mean_q - dq_q[MEAN_BITS-1:0] - MEAN_BITS'(rnd);
          end
        end
        OP_FIN_M2: begin
          if (up_q) begin
            m2_q <= m2_q + dq_q;
          end else begin
            m2_q <= m2_q - dq_q - MOM_BITS'(rnd);
          end
        end
        OP_RESTART: begin
          mean_q <= xs;
          m2_q   <= xsq_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cw.op)
      OP_LOAD: begin
        if (in_acc) begin
          n_q <= sample_index_i;
          x_q <= sample_value_i;
        end
      end
      OP_SQX: xsq_q <= {mul_p[2*SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}};
      OP_SET_MEAN: begin
        rem_q <= '0;
        if (xs >= mean_q) begin
          up_q <= 1'b1;
          dq_q <= {xs - mean_q, {SAMPLE_BITS{1'b0}}};
        end else begin
          up_q <= 1'b0;
          dq_q <= {mean_q - xs, {SAMPLE_BITS{1'b0}}};
        end
      end
      OP_SET_M2: begin
        rem_q <= '0;
        if (xsq_q >= m2_q) begin
          up_q <= 1'b1;
          dq_q <= xsq_q - m2_q;
        end else begin
          up_q <= 1'b0;
          dq_q <= m2_q - xsq_q;
        end
      end
      OP_DIV: begin
        rem_q <= q_bit ? r2_sub[REM_BITS-1:0] : r2[REM_BITS-1:0];
        dq_q  <= {dq_q[MOM_BITS-2:0], q_bit};
      end
      OP_SQM:     prod_q <= mul_p;
      OP_VAR:     var_q  <= (m2_q > msq) ? (m2_q - msq) : '0;
      OP_RESTART: var_q  <= '0;
      OP_EMIT: begin
        if (!out_busy) begin
          mean_o_q <= mean_q;
          var_o_q  <= var_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign mean_out_o     = mean_o_q;
  assign variance_out_o = var_o_q;

  `RMV_ASSERT_NEXT(a_accept_to_square, clk_i, rst_ni, in_acc, step_q == ST_SQX,
                   "accepted transfer did not start the program")
  `RMV_ASSERT_NOW(a_rem_below_divisor, clk_i, rst_ni,
                  (step_q == ST_FIN_M) || (step_q == ST_FIN_S), rem_q < div_d,
                  "divider remainder not below divisor")
  `RMV_ASSERT_NEXT(a_var_clamped, clk_i, rst_ni, step_q == ST_VAR, var_q <= m2_q,
                   "variance exceeds second moment")
  `RMV_ASSERT_NEXT(a_emit_waits, clk_i, rst_ni, (step_q == ST_EMIT) && out_busy,
                   (step_q == ST_EMIT) && out_valid_o,
                   "result overwritten while output stalled")

endmodule

`default_nettype wire
